// ----- design/crd_pkg.sv -----
// crd_pkg: widths, stage types and register indexes for the camera ray direction block
// no dependencies
package crd_pkg;

    localparam int COORD_W       = 17;
    localparam int SCALE_W       = 16;
    localparam int BASIS_W       = 48;
    localparam int COMP_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int COORD_FRAC    = 16;
    localparam int SCALE_FRAC    = 12;
    localparam int ALIGN_SHIFT   = COORD_FRAC + SCALE_FRAC;
    localparam int OFS_W         = 36;
    localparam int SUM_W         = 52;
    localparam int MAG_W         = SUM_W - 1;
    localparam int RED_W         = 30;
    localparam int SHIFT_W       = 5;
    localparam int SQ_W          = 2 * RED_W;
    localparam int SSQ_W         = SQ_W + 2;
    localparam int SQRT_STAGES   = SSQ_W / 2 - 0;
    localparam int ROOT_W        = SQRT_STAGES;
    localparam int VEC_FRAC      = 14;
    localparam int QUO_W         = VEC_FRAC + 1;
    localparam int NUM_W         = RED_W + VEC_FRAC + 1;
    localparam int PIPE_LATENCY  = 8 + SQRT_STAGES + QUO_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_FORWARD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HSCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VSCALE  = 3'd4;

    typedef struct packed {
        logic                       zero;
        logic [2:0]                 neg;
        logic [2:0][RED_W-1:0]      mag;
        logic [SSQ_W-1:0]           rem;
        logic [ROOT_W-1:0]          root;
    } sqrt_stage_t;

    typedef struct packed {
        logic                       zero;
        logic [2:0]                 neg;
        logic [ROOT_W-1:0]          den;
        logic [2:0][NUM_W-1:0]      rem;
        logic [2:0][QUO_W-1:0]      quo;
    } div_stage_t;

endpackage

// ----- design/camera_ray_direction_top.sv -----
// camera_ray_direction_top: pinhole camera ray generation, fully pipelined
// depends on crd_pkg
//
// channel   dir  handshake          payload
// input     in   start / busy       pixel_x, pixel_y
// result    out  done (one cycle)   dir_x, dir_y, dir_z
// config    in   cfg_we             cfg_index, cfg_data
//
// one item enters every cycle; busy is always low
// each result passes through 8 arithmetic stages, 31 square root stages (one root
// bit each), 16 divider stages (a load stage, then one quotient bit each) and
// the output register
// rst_n clears all valid bits and loads the default camera basis
// the receiver cannot stall, so the pipeline always advances
module camera_ray_direction_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [crd_pkg::COORD_W-1:0]   pixel_x,
    input  logic [crd_pkg::COORD_W-1:0]   pixel_y,
    input  logic                          cfg_we,
    input  logic [crd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crd_pkg::BASIS_W-1:0]   cfg_data,
    output logic                          done,
    output logic signed [crd_pkg::COMP_W-1:0] dir_x,
    output logic signed [crd_pkg::COMP_W-1:0] dir_y,
    output logic signed [crd_pkg::COMP_W-1:0] dir_z
);
    import crd_pkg::*;

    // configuration registers
    logic [BASIS_W-1:0] fwd_reg, right_reg, up_reg;
    logic [SCALE_W-1:0] hscale_reg, vscale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg    <= 48'd16384;
            right_reg  <= 48'd16384 << 32;
            up_reg     <= 48'd16384 << 16;
            hscale_reg <= 16'd4096;
            vscale_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORWARD: fwd_reg    <= cfg_data;
                REG_RIGHT:   right_reg  <= cfg_data;
                REG_UP:      up_reg     <= cfg_data;
                REG_HSCALE:  hscale_reg <= cfg_data[SCALE_W-1:0];
                REG_VSCALE:  vscale_reg <= cfg_data[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits of the arithmetic stages 1..7
    logic [7:1] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[6:1], start};
    end

    // stage 1: screen offsets px = (2x-1)*hscale, py = (1-2y)*vscale
    logic signed [COORD_W+1:0] sx, sy;
    logic signed [OFS_W-1:0]   px_next, py_next, px_reg, py_reg;

    always_comb
    begin
        sx = $signed({1'b0, pixel_x, 1'b0}) - $signed(19'd65536);
        sy = $signed(19'd65536) - $signed({1'b0, pixel_y, 1'b0});
        px_next = sx * $signed({1'b0, hscale_reg});
        py_next = sy * $signed({1'b0, vscale_reg});
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
    end

    // stage 2: basis products; component 0 is x (high field)
    logic signed [2:0][SUM_W-1:0]  pr_reg, pu_reg;
    logic        [2:0][COMP_W-1:0] pf_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pr_reg[k] <= $signed(right_reg[BASIS_W-1-COMP_W*k -: COMP_W]) * px_reg;
            pu_reg[k] <= $signed(up_reg[BASIS_W-1-COMP_W*k -: COMP_W]) * py_reg;
            pf_reg[k] <= fwd_reg[BASIS_W-1-COMP_W*k -: COMP_W];
        end
    end

    // stage 3: v = forward*align + right*px + up*py
    logic [2:0][SUM_W-1:0] c_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            c_reg[k] <= {{(SUM_W-COMP_W-ALIGN_SHIFT){pf_reg[k][COMP_W-1]}}, pf_reg[k],
                         {ALIGN_SHIFT{1'b0}}} + pr_reg[k] + pu_reg[k];
    end

    // stage 4: sign and magnitude
    logic [2:0]            neg4_reg;
    logic [2:0][MAG_W-1:0] mag4_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            neg4_reg[k] <= c_reg[k][SUM_W-1];
            mag4_reg[k] <= c_reg[k][SUM_W-1] ? MAG_W'(-c_reg[k]) : c_reg[k][MAG_W-1:0];
        end
    end

    // stage 5: reduction shift from the leading one of the largest magnitude
    // (the bit length of the or of all three equals that of the maximum)
    logic [MAG_W-1:0]      orv;
    logic [5:0]            blen;
    logic [SHIFT_W-1:0]    shift_next, shift_reg;
    logic                  zero5_reg;
    logic [2:0]            neg5_reg;
    logic [2:0][MAG_W-1:0] mag5_reg;

    always_comb
    begin
        orv  = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        blen = '0;
        for (int i = 0; i < MAG_W; i++)
            if (orv[i])
                blen = 6'(i + 1);
        shift_next = (blen > 6'(RED_W)) ? SHIFT_W'(blen - 6'(RED_W)) : '0;
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        zero5_reg <= (orv == '0);
        neg5_reg  <= neg4_reg;
        mag5_reg  <= mag4_reg;
    end

    // stage 6: reduced magnitudes below 2^30
    logic                  zero6_reg;
    logic [2:0]            neg6_reg;
    logic [2:0][RED_W-1:0] mag6_reg;

    always_ff @(posedge clk)
    begin
        zero6_reg <= zero5_reg;
        neg6_reg  <= neg5_reg;
        for (int k = 0; k < 3; k++)
            mag6_reg[k] <= RED_W'(mag5_reg[k] >> shift_reg);
    end

    // stage 7: squares
    logic                  zero7_reg;
    logic [2:0]            neg7_reg;
    logic [2:0][RED_W-1:0] mag7_reg;
    logic [2:0][SQ_W-1:0]  sq7_reg;

    always_ff @(posedge clk)
    begin
        zero7_reg <= zero6_reg;
        neg7_reg  <= neg6_reg;
        mag7_reg  <= mag6_reg;
        for (int k = 0; k < 3; k++)
            sq7_reg[k] <= mag6_reg[k] * mag6_reg[k];
    end

    // stage 8 and square root: one root bit per stage
    logic        [SQRT_STAGES:0] sq_v_reg;
    sqrt_stage_t                 sq_reg [0:SQRT_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else
            sq_v_reg[0] <= v_reg[7];
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0].zero <= zero7_reg;
        sq_reg[0].neg  <= neg7_reg;
        sq_reg[0].mag  <= mag7_reg;
        sq_reg[0].rem  <= SSQ_W'(sq7_reg[0]) + SSQ_W'(sq7_reg[1]) + SSQ_W'(sq7_reg[2]);
        sq_reg[0].root <= '0;
    end

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_sqrt
        localparam int BITPOS = SQRT_STAGES - 1 - s;
        logic [63:0] trial;
        sqrt_stage_t nxt;

        always_comb
        begin
            trial = (64'(sq_reg[s].root) << (BITPOS + 1)) + (64'd1 << (2 * BITPOS));
            nxt   = sq_reg[s];
            if (64'(sq_reg[s].rem) >= trial)
            begin
                nxt.rem  = sq_reg[s].rem - SSQ_W'(trial);
                nxt.root = sq_reg[s].root | (ROOT_W'(1) << BITPOS);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[s+1] <= 1'b0;
            else
                sq_v_reg[s+1] <= sq_v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            sq_reg[s+1] <= nxt;
        end
    end

    // divider: (mag*2^14 + d/2) / d, one quotient bit per stage, three lanes
    logic       [QUO_W:0] dv_v_reg;
    div_stage_t           dv_reg [0:QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else
            dv_v_reg[0] <= sq_v_reg[SQRT_STAGES];
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0].zero <= sq_reg[SQRT_STAGES].zero;
        dv_reg[0].neg  <= sq_reg[SQRT_STAGES].neg;
        dv_reg[0].den  <= sq_reg[SQRT_STAGES].root;
        dv_reg[0].quo  <= '0;
        for (int k = 0; k < 3; k++)
            dv_reg[0].rem[k] <= {1'b0, sq_reg[SQRT_STAGES].mag[k], {VEC_FRAC{1'b0}}}
                                + NUM_W'(sq_reg[SQRT_STAGES].root >> 1);
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_div
        localparam int QPOS = QUO_W - 1 - s;
        logic [NUM_W:0] dsh;
        div_stage_t     nxt;

        always_comb
        begin
            dsh = (NUM_W+1)'(dv_reg[s].den) << QPOS;
            nxt = dv_reg[s];
            for (int k = 0; k < 3; k++)
                if ({1'b0, dv_reg[s].rem[k]} >= dsh)
                begin
                    nxt.rem[k] = dv_reg[s].rem[k] - NUM_W'(dsh);
                    nxt.quo[k] = dv_reg[s].quo[k] | (QUO_W'(1) << QPOS);
                end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[s+1] <= 1'b0;
            else
                dv_v_reg[s+1] <= dv_v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            dv_reg[s+1] <= nxt;
        end
    end

    // output register: apply sign, zero vector gives zero
    logic                   done_reg;
    logic [2:0][COMP_W-1:0] dir_next, dir_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dv_reg[QUO_W].zero)
                dir_next[k] = '0;
            else if (dv_reg[QUO_W].neg[k])
                dir_next[k] = -{1'b0, dv_reg[QUO_W].quo[k]};
            else
                dir_next[k] = {1'b0, dv_reg[QUO_W].quo[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_v_reg[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        dir_reg <= dir_next;
    end

    assign done  = done_reg;
    assign dir_x = $signed(dir_reg[0]);
    assign dir_y = $signed(dir_reg[1]);
    assign dir_z = $signed(dir_reg[2]);

    // every accepted item leaves after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_LATENCY done)
        else $error("result missing after pipeline latency");

    // nothing leaves that was not accepted
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LATENCY))
        else $error("result without an accepted item");

    // a nonzero vector always yields a nonzero root
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v_reg[SQRT_STAGES] && !sq_reg[SQRT_STAGES].zero |-> sq_reg[SQRT_STAGES].root != '0)
        else $error("zero root for a nonzero vector");

    // unit vector components stay within one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dir_x <= 16'sd16384) && (dir_x >= -16'sd16384)
              && (dir_y <= 16'sd16384) && (dir_y >= -16'sd16384)
              && (dir_z <= 16'sd16384) && (dir_z >= -16'sd16384))
        else $error("direction component beyond unit range");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking regression for camera_ray_direction_top
// depends on crd_pkg and camera_ray_direction_top; needs no other files
// a directed table is run first, then random pixels under several camera setups
`timescale 1ns / 100ps

module testbench;
    import crd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int NUM_PHASES = 8;

    // one directed row: a register write or a pixel, maybe with a typed-in answer
    typedef enum logic { ROW_PIXEL, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [CFG_IDX_W-1:0]        idx;
        logic [BASIS_W-1:0]          data;
        logic [COORD_W-1:0]          x;
        logic [COORD_W-1:0]          y;
        bit                          typed;
        logic signed [COMP_W-1:0]    ex;
        logic signed [COMP_W-1:0]    ey;
        logic signed [COMP_W-1:0]    ez;
    } plan_row_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } ray_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [COORD_W-1:0]          pixel_x;
    logic [COORD_W-1:0]          pixel_y;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [BASIS_W-1:0]          cfg_data;
    logic                        done;
    logic signed [COMP_W-1:0]    dir_x;
    logic signed [COMP_W-1:0]    dir_y;
    logic signed [COMP_W-1:0]    dir_z;

    // camera registers as the block should hold them
    logic [BASIS_W-1:0] cam_forward;
    logic [BASIS_W-1:0] cam_right;
    logic [BASIS_W-1:0] cam_up;
    logic [SCALE_W-1:0] cam_hscale;
    logic [SCALE_W-1:0] cam_vscale;

    ray_t      pending_rays[$];
    plan_row_t plan[$];
    int        mismatches;
    int        cycles;
    int        sender_idle_pct;

    camera_ray_direction_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // signed Q1.14 component of a packed basis, sel 2 = x, 1 = y, 0 = z
    function automatic longint basis_field(logic [BASIS_W-1:0] packed_vec, int sel);
        logic signed [COMP_W-1:0] f;
        f = packed_vec[COMP_W*sel +: COMP_W];
        return longint'(f);
    endfunction

    // floor of the square root, two bits of the radicand per step
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > n)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (n >= root + bitpos)
            begin
                n = n - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // unit ray through one pixel for the current camera
    function automatic ray_t ray_through_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        longint          one_coord;
        longint          ofs_h;
        longint          ofs_v;
        longint          sum_c;
        longint unsigned mag[3];
        bit              neg[3];
        longint unsigned biggest;
        longint unsigned sumsq;
        longint unsigned root;
        longint unsigned quo;
        logic [COMP_W-1:0] part[3];
        ray_t            r;
        one_coord = longint'(1) << COORD_FRAC;
        ofs_h = (2 * longint'(x) - one_coord) * longint'(cam_hscale);
        ofs_v = (one_coord - 2 * longint'(y)) * longint'(cam_vscale);
        biggest = 0;
        for (int k = 0; k < 3; k++)
        begin
            sum_c = basis_field(cam_forward, 2 - k) * (longint'(1) << ALIGN_SHIFT)
                  + basis_field(cam_right, 2 - k) * ofs_h
                  + basis_field(cam_up, 2 - k) * ofs_v;
            neg[k] = sum_c < 0;
            mag[k] = neg[k] ? longint'(-sum_c) : sum_c;
            if (mag[k] > biggest)
                biggest = mag[k];
        end
        if (biggest == 0)
            return '0;
        // bring the largest magnitude under 2^30, all three together
        while (biggest >= (64'd1 << RED_W))
        begin
            biggest = biggest >> 1;
            for (int k = 0; k < 3; k++)
                mag[k] = mag[k] >> 1;
        end
        sumsq = 0;
        for (int k = 0; k < 3; k++)
            sumsq = sumsq + mag[k] * mag[k];
        root = floor_sqrt(sumsq);
        for (int k = 0; k < 3; k++)
        begin
            quo = ((mag[k] << VEC_FRAC) + (root >> 1)) / root;
            part[k] = neg[k] ? COMP_W'(-quo) : COMP_W'(quo);
        end
        r.x = part[0];
        r.y = part[1];
        r.z = part[2];
        return r;
    endfunction

    // one line per mismatch, and count it
    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // results come one cycle wide, compare against the oldest pending ray
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rays.size() == 0)
                report_mismatch("result with no item outstanding");
            else
            begin
                ray_t want;
                want = pending_rays.pop_front();
                if (dir_x !== want.x)
                    report_mismatch($sformatf("dir_x got %0d expected %0d", dir_x, want.x));
                if (dir_y !== want.y)
                    report_mismatch($sformatf("dir_y got %0d expected %0d", dir_y, want.y));
                if (dir_z !== want.z)
                    report_mismatch($sformatf("dir_z got %0d expected %0d", dir_z, want.z));
            end
        end
    end

    // watchdog, the run must finish well before this
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("camera_ray_direction_top regression: fail");
            $finish;
        end
    end

    // hold start with the pixel until an edge takes it; leaves start high
    task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              bit typed, ray_t typed_ray);
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do
            @(posedge clk);
        while (busy);
        pending_rays.push_back(typed ? typed_ray : ray_through_pixel(x, y));
    endtask

    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // sender pauses until every outstanding ray has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_rays.size() != 0)
            @(posedge clk);
    endtask

    // one register write; caller lowers cfg_we when the group is done
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BASIS_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_FORWARD: cam_forward = data;
            REG_RIGHT:   cam_right   = data;
            REG_UP:      cam_up      = data;
            REG_HSCALE:  cam_hscale  = data[SCALE_W-1:0];
            REG_VSCALE:  cam_vscale  = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        plan_row_t row;
        row = '{kind: ROW_PIXEL, default: '0};
        row.x = x;
        row.y = y;
        plan.push_back(row);
    endtask

    task automatic add_known(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             int ex, int ey, int ez);
        plan_row_t row;
        row = '{kind: ROW_PIXEL, default: '0};
        row.x = x;
        row.y = y;
        row.typed = 1'b1;
        row.ex = COMP_W'(ex);
        row.ey = COMP_W'(ey);
        row.ez = COMP_W'(ez);
        plan.push_back(row);
    endtask

    task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [BASIS_W-1:0] data);
        plan_row_t row;
        row = '{kind: ROW_REG, default: '0};
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endtask

    // basis components favor the extremes of Q1.14
    function automatic logic [COMP_W-1:0] pick_component();
        case ($urandom_range(0, 7))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h0000;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h1000;
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    // mostly inside the screen, sometimes anywhere in the 17 bits
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1: return COORD_W'($urandom_range(0, 1) << COORD_FRAC);
            default: return COORD_W'($urandom_range(0, 1 << COORD_FRAC));
        endcase
    endfunction

    initial
    begin
        ray_t typed_ray;
        rst_n      = 1'b0;
        mismatches = 0;
        cycles     = 0;
        start     <= 1'b0;
        pixel_x   <= '0;
        pixel_y   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cam_forward = 48'h0000_0000_4000;
        cam_right   = 48'h4000_0000_0000;
        cam_up      = 48'h0000_4000_0000;
        cam_hscale  = 16'h1000;
        cam_vscale  = 16'h1000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part; the reset camera looks down +z
        add_known(17'h08000, 17'h08000, 0, 0, 16384);     // screen center
        add_pixel(17'h00000, 17'h00000);                  // corners
        add_pixel(17'h10000, 17'h10000);
        add_pixel(17'h00000, 17'h10000);
        add_pixel(17'h10000, 17'h00000);
        add_pixel(17'h1FFFF, 17'h1FFFF);                  // far past the edge, no clamp
        add_pixel(17'h1FFFF, 17'h00000);
        add_pixel(17'h00000, 17'h1FFFF);
        add_pixel(17'h0ABCD, 17'h15555);
        add_reg(REG_FORWARD, 48'h0);                      // zero-length vector at center
        add_known(17'h08000, 17'h08000, 0, 0, 0);
        add_reg(REG_FORWARD, 48'h0000_0000_C000);         // looking down -z
        add_known(17'h08000, 17'h08000, 0, 0, -16384);
        add_reg(REG_RIGHT, 48'h7FFF_8000_1234);           // basis not of unit length
        add_pixel(17'h00000, 17'h1FFFF);
        add_reg(REG_UP, 48'h8000_8000_8000);
        add_reg(REG_HSCALE, 48'hFFFF);
        add_reg(REG_VSCALE, 48'h0);
        add_pixel(17'h1FFFF, 17'h1FFFF);
        add_pixel(17'h00000, 17'h00000);
        add_reg(REG_HSCALE, 48'h0);
        add_reg(REG_VSCALE, 48'hFFFF);
        add_pixel(17'h00005, 17'h11170);
        add_pixel(17'h10000, 17'h0FFFF);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                // registers only change with the pipeline empty
                drain();
                write_reg(plan[i].idx, plan[i].data);
                cfg_we <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                typed_ray.x = plan[i].ex;
                typed_ray.y = plan[i].ey;
                typed_ray.z = plan[i].ez;
                send_pixel(plan[i].x, plan[i].y, plan[i].typed, typed_ray);
            end
        end

        // random part: a camera written per phase (the default one in phase 0), sender idling varies by phase
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            if (phase == 0)
            begin
                write_reg(REG_FORWARD, 48'h0000_0000_4000);
                write_reg(REG_RIGHT,   48'h4000_0000_0000);
                write_reg(REG_UP,      48'h0000_4000_0000);
                write_reg(REG_HSCALE,  48'h1000);
                write_reg(REG_VSCALE,  48'h1000);
            end
            else
            begin
                write_reg(REG_FORWARD, {pick_component(), pick_component(), pick_component()});
                write_reg(REG_RIGHT,   {pick_component(), pick_component(), pick_component()});
                write_reg(REG_UP,      {pick_component(), pick_component(), pick_component()});
                write_reg(REG_HSCALE,  BASIS_W'(pick_scale()));
                write_reg(REG_VSCALE,  BASIS_W'(pick_scale()));
            end
            cfg_we <= 1'b0;
            @(posedge clk);
            // the receiver cannot stall; only the sender idles, by a share that depends on the phase
            case (phase % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 82;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 11;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain();
                while ($urandom_range(1, 100) <= sender_idle_pct)
                    idle_cycle();
                send_pixel(pick_coord(), pick_coord(), 1'b0, '0);
            end
        end

        drain();
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && pending_rays.size() == 0)
            $display("camera_ray_direction_top regression: pass");
        else
            $display("camera_ray_direction_top regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/crd_pkg.sv
design/camera_ray_direction_top.sv
tb/testbench.sv
